// ===== sv/mbd_pkg.sv =====
package mbd_pkg;

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  // bytes held back ahead of the closing boundary
  localparam int TAIL_DROP = 2;

  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] COUNT_MAX = 6'd63;

  localparam int LEN_RAW_W = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int BND_REGS = 4;
  localparam int BND_BITS = BND_REGS * CFG_DATA_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEN   = 3'd0,
    REG_BND_A = 3'd1,
    REG_BND_B = 3'd2,
    REG_BND_C = 3'd3,
    REG_BND_D = 3'd4
  } reg_idx_t;

  typedef enum logic [5:0] {
    M_SEARCH  = 6'b000001,
    M_BND_CR  = 6'b000010,
    M_BND_LF  = 6'b000100,
    M_HEAD    = 6'b001000,
    M_HEAD_CR = 6'b010000,
    M_PAYLOAD = 6'b100000
  } mode_t;

  // window control: fresh treats the window as empty before this word
  typedef struct packed {
    logic fresh;
    logic push;
    logic clear;
  } win_ctrl_t;

endpackage

// ===== sv/mbd_match.sv =====
module mbd_match #(
  parameter int MAX_BOUNDARY = 32,
  parameter int IDX_W = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mbd_pkg::win_ctrl_t            ctrl,
  input  logic [7:0]                    stream_byte,
  input  logic [mbd_pkg::BND_BITS-1:0]  boundary,
  input  logic [IDX_W-1:0]              len_idx,
  output logic                          hit
);

  // bit k: the last k+1 window words equal boundary bytes 0..k
  logic [MAX_BOUNDARY-1:0] prefix;
  logic [MAX_BOUNDARY-1:0] prefix_old;
  logic [MAX_BOUNDARY-1:0] prefix_next;
  logic [MAX_BOUNDARY-1:0] eq;

  assign prefix_old = ctrl.fresh ? '0 : prefix;

  always_comb begin
    for (int k = 0; k < MAX_BOUNDARY; k++) begin
      eq[k] = (stream_byte == boundary[8*k +: 8]);
    end
    prefix_next[0] = eq[0];
    for (int k = 1; k < MAX_BOUNDARY; k++) begin
      prefix_next[k] = prefix_old[k-1] & eq[k];
    end
  end

  assign hit = prefix_next[len_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix <= '0;
    end else if (ctrl.clear) begin
      prefix <= '0;
    end else if (ctrl.push) begin
      prefix <= prefix_next;
    end
  end

endmodule

// ===== sv/multipart_boundary_deframer.sv =====
// A result word is in the output register in the cycle after its input word is accepted.
// Throughput: one input word per cycle; input stalls only while a result waits on out_stall.
// Boundary matching uses a running prefix-match vector, so any length costs one compare stage.
// cfg_ready is always high; a register write takes effect at once and restarts the search.
// Reset (synchronous): boundary length 1, boundary bytes zero, parser searching, window empty.
module multipart_boundary_deframer #(
  parameter int MAX_BOUNDARY = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         stream_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         payload_byte,
  output logic                               byte_valid,
  output logic                               frame_start,
  output logic                               frame_end,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mbd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int WIN    = MAX_BOUNDARY + 2;
  localparam int FILL_W = $clog2(WIN + 1);
  localparam int RING_W = $clog2(WIN);
  localparam int RING   = 1 << RING_W;
  localparam int LEN_W  = $clog2(MAX_BOUNDARY + 1);
  localparam int IDX_W  = (MAX_BOUNDARY > 1) ? $clog2(MAX_BOUNDARY) : 1;
  localparam int CMP_W  = 8;

  // configuration
  logic [mbd_pkg::LEN_RAW_W-1:0]                      boundary_len;
  logic [mbd_pkg::BND_REGS-1:0][mbd_pkg::CFG_DATA_W-1:0] bnd_regs;
  logic                                               cfg_we;
  logic                                               cfg_clr;

  // parser state
  mbd_pkg::mode_t            mode, mode_next;
  logic [7:0]                ring [RING];
  logic [RING_W-1:0]         wr_ptr, wr_ptr_next;
  logic [FILL_W-1:0]         fill;
  logic [mbd_pkg::CNT_W-1:0] count, count_next;
  logic                      line_empty, line_empty_next;
  logic                      first_pending, first_pending_next;

  // per-word logic
  logic                      acc;
  logic                      fresh, push, clear;
  mbd_pkg::win_ctrl_t        wctrl;
  logic                      hit;
  logic [LEN_W-1:0]          eff_len;
  logic [IDX_W-1:0]          len_idx;
  logic [RING_W-1:0]         rd_addr;
  logic [7:0]                tap;
  logic [mbd_pkg::CNT_W-1:0] cnt_old, cnt_new;
  logic [FILL_W-1:0]         fill_old;
  logic                      fp_old;
  logic                      ready, bnd_end;
  logic                      emit;
  logic [7:0]                e_byte;
  logic                      e_valid, e_start, e_end;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign cfg_clr   = cfg_we & (cfg_index <= mbd_pkg::REG_BND_D);
  assign in_stall  = out_valid & out_stall;
  assign acc       = in_valid & ~in_stall;

  always_comb begin
    if (boundary_len == '0) begin
      eff_len = LEN_W'(1);
    end else if (CMP_W'(boundary_len) > CMP_W'(MAX_BOUNDARY)) begin
      eff_len = LEN_W'(MAX_BOUNDARY);
    end else begin
      eff_len = LEN_W'(boundary_len);
    end
  end

  assign len_idx = IDX_W'(CMP_W'(eff_len) - CMP_W'(1));

  // window restarts empty on a failed CR/LF after a boundary and on the word after a header CR
  assign fresh = ((mode == mbd_pkg::M_BND_CR) && (stream_byte != mbd_pkg::CH_CR)) ||
                 ((mode == mbd_pkg::M_BND_LF) && (stream_byte != mbd_pkg::CH_LF)) ||
                 (mode == mbd_pkg::M_HEAD_CR);

  assign wctrl = '{fresh: fresh, push: push, clear: clear};

  mbd_match #(
    .MAX_BOUNDARY (MAX_BOUNDARY),
    .IDX_W        (IDX_W)
  ) u_match (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (wctrl),
    .stream_byte (stream_byte),
    .boundary    (bnd_regs),
    .len_idx     (len_idx),
    .hit         (hit)
  );

  assign cnt_old  = fresh ? '0 : count;
  assign fill_old = fresh ? '0 : fill;
  assign fp_old   = fresh ? 1'b1 : first_pending;
  assign cnt_new  = (cnt_old == mbd_pkg::COUNT_MAX) ? cnt_old : cnt_old + 1'b1;

  assign ready = (CMP_W'(cnt_new) >= CMP_W'(eff_len) + CMP_W'(mbd_pkg::TAIL_DROP + 1)) &&
                 (CMP_W'(fill_old) >= CMP_W'(eff_len) + CMP_W'(mbd_pkg::TAIL_DROP));
  assign bnd_end = (CMP_W'(cnt_new) >= CMP_W'(eff_len) + CMP_W'(1)) && hit;

  always_comb begin
    mode_next          = mode;
    count_next         = count;
    line_empty_next    = line_empty;
    first_pending_next = first_pending;
    push    = 1'b0;
    clear   = 1'b0;
    emit    = 1'b0;
    e_byte  = '0;
    e_valid = 1'b0;
    e_start = 1'b0;
    e_end   = 1'b0;
    if (cfg_clr) begin
      clear              = 1'b1;
      mode_next          = mbd_pkg::M_SEARCH;
      count_next         = '0;
      line_empty_next    = 1'b1;
      first_pending_next = 1'b1;
    end else if (acc) begin
      unique case (mode)
        mbd_pkg::M_SEARCH, mbd_pkg::M_BND_CR, mbd_pkg::M_BND_LF: begin
          if ((mode == mbd_pkg::M_BND_CR) && (stream_byte == mbd_pkg::CH_CR)) begin
            mode_next = mbd_pkg::M_BND_LF;
          end else if ((mode == mbd_pkg::M_BND_LF) && (stream_byte == mbd_pkg::CH_LF)) begin
            line_empty_next = 1'b1;
            mode_next       = mbd_pkg::M_HEAD;
          end else begin
            // search, or restart the search with this word
            count_next         = '0;
            line_empty_next    = 1'b1;
            first_pending_next = 1'b1;
            if (hit) begin
              clear     = 1'b1;
              mode_next = mbd_pkg::M_BND_CR;
            end else begin
              push      = 1'b1;
              mode_next = mbd_pkg::M_SEARCH;
            end
          end
        end
        mbd_pkg::M_HEAD: begin
          if (stream_byte == mbd_pkg::CH_CR) begin
            mode_next = mbd_pkg::M_HEAD_CR;
          end else begin
            line_empty_next = 1'b0;
          end
        end
        mbd_pkg::M_HEAD_CR, mbd_pkg::M_PAYLOAD: begin
          if ((mode == mbd_pkg::M_HEAD_CR) && (stream_byte == mbd_pkg::CH_LF)) begin
            if (line_empty) begin
              clear              = 1'b1;
              mode_next          = mbd_pkg::M_PAYLOAD;
              count_next         = '0;
              first_pending_next = 1'b1;
            end else begin
              line_empty_next = 1'b1;
              mode_next       = mbd_pkg::M_HEAD;
            end
          end else if (bnd_end) begin
            // close the frame; the boundary opens the next one
            emit = 1'b1;
            if (ready) begin
              e_byte  = tap;
              e_valid = 1'b1;
              e_start = fp_old;
            end else begin
              e_start = 1'b1;
            end
            e_end              = 1'b1;
            clear              = 1'b1;
            mode_next          = mbd_pkg::M_BND_CR;
            count_next         = '0;
            line_empty_next    = 1'b1;
            first_pending_next = 1'b1;
          end else begin
            if (ready) begin
              emit    = 1'b1;
              e_byte  = tap;
              e_valid = 1'b1;
              e_start = fp_old;
            end
            push               = 1'b1;
            mode_next          = mbd_pkg::M_PAYLOAD;
            count_next         = cnt_new;
            line_empty_next    = 1'b1;
            first_pending_next = ready ? 1'b0 : fp_old;
          end
        end
        default: begin
          mode_next = mbd_pkg::M_SEARCH;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      boundary_len <= mbd_pkg::LEN_RAW_W'(1);
      bnd_regs     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mbd_pkg::REG_LEN:   boundary_len <= cfg_data[mbd_pkg::LEN_RAW_W-1:0];
        mbd_pkg::REG_BND_A: bnd_regs[0] <= cfg_data;
        mbd_pkg::REG_BND_B: bnd_regs[1] <= cfg_data;
        mbd_pkg::REG_BND_C: bnd_regs[2] <= cfg_data;
        mbd_pkg::REG_BND_D: bnd_regs[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= mbd_pkg::M_SEARCH;
      count         <= '0;
      line_empty    <= 1'b1;
      first_pending <= 1'b1;
    end else begin
      mode          <= mode_next;
      count         <= count_next;
      line_empty    <= line_empty_next;
      first_pending <= first_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (clear) begin
      fill <= '0;
    end else if (push) begin
      if (fresh) begin
        fill <= FILL_W'(1);
      end else if (fill != FILL_W'(WIN)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // byte window: ring buffer; the delayed tap is fetched in the cycle before its use
  assign wr_ptr_next = push ? wr_ptr + 1'b1 : wr_ptr;
  assign rd_addr     = wr_ptr_next - RING_W'(eff_len) - RING_W'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ring[wr_ptr] <= stream_byte;
    end
    tap <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      payload_byte <= e_byte;
      byte_valid   <= e_valid;
      frame_start  <= e_start;
      frame_end    <= e_end;
    end
  end

endmodule
